>>> src/f2i_pkg.sv
// ----------------------------------------------------------------------------
// f2i_pkg: shared types and constants for the float to integer converter.
// Holds the operation codes and the saturation limits of both target widths.
// ----------------------------------------------------------------------------
package f2i_pkg;

  // Operation selector: bit 1 picks double input, bit 0 picks 64-bit output.
  typedef enum logic [1:0] {
    OP_S_TO_W = 2'd0,
    OP_S_TO_L = 2'd1,
    OP_D_TO_W = 2'd2,
    OP_D_TO_L = 2'd3
  } f2i_op_t;

  localparam logic [63:0] SAT32_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] SAT32_MIN = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] SAT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT64_MIN = 64'h8000_0000_0000_0000;

endpackage

>>> src/f2i_core.sv
// ----------------------------------------------------------------------------
// f2i_core: combinational float to integer conversion.
// Unpacks the operand, classifies it and shifts the significand into place.
// ----------------------------------------------------------------------------
module f2i_core import f2i_pkg::*; (
  input  logic [1:0]  op,
  input  logic [63:0] operand_bits,
  output logic [63:0] converted_value
);

  logic        is_dbl;
  logic        wide;
  logic        neg;
  logic [10:0] expf;
  logic [51:0] frac;
  logic        exp_max;
  logic        frac_nz;
  logic [11:0] e;
  logic [52:0] sig;
  logic [63:0] mag;
  logic [63:0] sat_val;
  logic [11:0] lim;

  // Field extraction; a single is widened into double field positions.
  always_comb begin
    is_dbl = op[1];
    wide   = op[0];
    if (is_dbl) begin
      neg     = operand_bits[63];
      expf    = operand_bits[62:52];
      frac    = operand_bits[51:0];
      exp_max = (operand_bits[62:52] == 11'h7FF);
      e       = {1'b0, operand_bits[62:52]} - 12'd1023;
    end else begin
      neg     = operand_bits[31];
      expf    = {3'b000, operand_bits[30:23]};
      frac    = {operand_bits[22:0], 29'd0};
      exp_max = (operand_bits[30:23] == 8'hFF);
      e       = {4'b0000, operand_bits[30:23]} - 12'd127;
    end
    frac_nz = (frac != 52'd0);
    lim     = wide ? 12'd63 : 12'd31;
    sig     = {1'b1, frac};
  end

  // Magnitude: exponent is known to lie in 0..62 when it is used.
  always_comb begin
    logic [115:0] wide_sig;
    wide_sig = {63'd0, sig} << e[5:0];
    mag      = wide_sig[115:52];
  end

  // Classification and sign application.
  always_comb begin
    sat_val = wide ? (neg ? SAT64_MIN : SAT64_MAX) : (neg ? SAT32_MIN : SAT32_MAX);
    priority if (exp_max) begin
      converted_value = frac_nz ? 64'd0 : sat_val;
    end else if (expf == 11'd0 || e[11]) begin
      converted_value = 64'd0;
    end else if (e >= lim) begin
      converted_value = sat_val;
    end else begin
      converted_value = neg ? (~mag + 64'd1) : mag;
    end
  end

endmodule

>>> src/float_to_integer_saturating_convert.sv
// ----------------------------------------------------------------------------
// float_to_integer_saturating_convert: saturating float to integer converter.
// Truncates a single or double toward zero into a 32- or 64-bit integer.
// ----------------------------------------------------------------------------
//   Channel  Ports                           Direction
//   in       in_valid/in_ready, op, bits     input
//   out      out_valid/out_ready, value      output
//
// One item per cycle while the output is not stalled; a taken item waits in the
// input register, its result is held in the result register. The conversion is
// a single combinational stage between the two registers. Reset empties both
// registers. A stalled output stalls the input only when both registers are full.
module float_to_integer_saturating_convert import f2i_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_converted_value
);

  logic        s1_vld_r;
  logic [1:0]  s1_op_r;
  logic [63:0] s1_bits_r;
  logic        s2_vld_r;
  logic [63:0] s2_val_r;
  logic [63:0] conv;
  logic        s2_take;

  f2i_core u_core (
    .op              (s1_op_r),
    .operand_bits    (s1_bits_r),
    .converted_value (conv)
  );

  // Pipeline advance control.
  assign s2_take  = !s2_vld_r || out_ready;
  assign in_ready = !s1_vld_r || s2_take;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_op_r   <= in_op;
      s1_bits_r <= in_operand_bits;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_take) begin
      s2_vld_r <= s1_vld_r;
    end
    if (s2_take && s1_vld_r) begin
      s2_val_r <= conv;
    end
  end

  assign out_valid           = s2_vld_r;
  assign out_converted_value = s2_val_r;

endmodule
